// ===== hdl/i2c_master_transfer_sequencer_core_macros.svh =====
// Assertion shorthands used by the checker of the sequencer core.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define I2CMS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition on the cycle after an antecedent.
`define I2CMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/i2cms_pkg.sv =====
package i2cms_pkg;

  // Buffer geometry
  localparam int BUFFER_DEPTH = 32;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LENGTH_W     = 5;
  localparam int INDEX_W      = 5;
  // position / length counters hold 0..BUFFER_DEPTH and any launch length
  localparam int CNT_W        = ($clog2(BUFFER_DEPTH + 1) > LENGTH_W) ?
                                $clog2(BUFFER_DEPTH + 1) : LENGTH_W;
  // one extra bit for length + 1 and range checks
  localparam int XA_W         = CNT_W + 1;

  // Host commands (s_tuser)
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LAUNCH = 2'd2,
    CMD_EVENT  = 2'd3
  } cmd_t;

  // Bus actions
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SEND   = 3'd1,
    ACT_START  = 3'd2,
    ACT_RSTART = 3'd3,
    ACT_ACK    = 3'd4,
    ACT_NACK   = 3'd5,
    ACT_STOP   = 3'd6,
    ACT_RESET  = 3'd7
  } action_t;

  // Bus status codes; anything above ST_DATA_W_NACK is a bus error
  localparam logic [3:0] ST_START        = 4'd0;
  localparam logic [3:0] ST_REP_START    = 4'd1;
  localparam logic [3:0] ST_ADDR_W_ACK   = 4'd2;
  localparam logic [3:0] ST_DATA_W_ACK   = 4'd3;
  localparam logic [3:0] ST_ADDR_R_ACK   = 4'd4;
  localparam logic [3:0] ST_DATA_R_ACK   = 4'd5;
  localparam logic [3:0] ST_DATA_R_NACK  = 4'd6;
  localparam logic [3:0] ST_IGNORED      = 4'd7;
  localparam logic [3:0] ST_ADDR_R_NACK  = 4'd8;
  localparam logic [3:0] ST_ADDR_W_NACK  = 4'd9;
  localparam logic [3:0] ST_DATA_W_NACK  = 4'd10;

  // Input word layout (s_tdata)
  localparam int IN_W        = 24;
  localparam int I_IDX_LO    = 0;
  localparam int I_DATA_LO   = 5;
  localparam int I_LEN_LO    = 13;
  localparam int I_RS_BIT    = 18;
  localparam int I_STAT_LO   = 19;

  // Output word layout (m_tdata)
  localparam int OUT_W       = 24;
  localparam int O_ACT_LO    = 0;
  localparam int O_TX_LO     = 3;
  localparam int O_RD_LO     = 11;
  localparam int O_BUSY_BIT  = 19;
  localparam int O_ERR_BIT   = 20;
  localparam int O_REF_BIT   = 21;

  typedef struct packed {
    cmd_t                cmd;
    logic [INDEX_W-1:0]  index;
    logic [7:0]          data_byte;
    logic [LENGTH_W-1:0] length;
    logic                restart_read;
    logic [3:0]          status;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] len;
    logic             restart_pending;
    logic             busy;
    logic             err;
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] tx_byte;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       error;
    logic       refused;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

// ===== hdl/i2cms_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/i2cms_step.sv =====
// Per-word decision logic: next state, buffer write and result from one word.
module i2cms_step (
  input  i2cms_pkg::item_t  item,
  input  i2cms_pkg::state_t state,
  input  logic [7:0]        rd_a,   // buf[index], buf[position] or buf[length]
  input  logic [7:0]        rd_b,   // buf[length + 1]
  output i2cms_pkg::state_t state_next,
  output i2cms_pkg::result_t res,
  output i2cms_pkg::wr_t    wr
);
  import i2cms_pkg::*;

  logic [CNT_W-1:0] eff_pos;
  logic [CNT_W-1:0] pos_inc;
  logic             pos_in_buf;

  always_comb begin
    state_next    = state;
    res           = '0;
    res.action    = ACT_NONE;
    wr            = '0;
    eff_pos       = state.pos;
    pos_inc       = state.pos;
    pos_in_buf    = XA_W'(state.pos) < XA_W'(BUFFER_DEPTH);

    case (item.cmd)
      CMD_WRITE: begin
        if (state.busy) begin
          res.refused = 1'b1;
        end else begin
          wr.we   = XA_W'(item.index) < XA_W'(BUFFER_DEPTH);
          wr.addr = ADDR_W'(item.index);
          wr.data = item.data_byte;
        end
      end
      CMD_READ: begin
        res.read_byte = rd_a;
      end
      CMD_LAUNCH: begin
        if (state.busy) begin
          res.refused = 1'b1;
        end else begin
          state_next.len             = CNT_W'(item.length);
          state_next.restart_pending = item.restart_read;
          state_next.pos             = '0;
          state_next.busy            = 1'b1;
          state_next.err             = 1'b0;
          res.action                 = ACT_START;
        end
      end
      default: begin
        if (state.busy) begin
          case (item.status) inside
            // start, repeated start, write-side acks: next byte or phase change
            [ST_START:ST_DATA_W_ACK]: begin
              eff_pos = (item.status <= ST_REP_START) ? '0 : state.pos;
              state_next.pos = eff_pos;
              if (eff_pos < state.len) begin
                res.tx_byte    = rd_a;
                state_next.pos = eff_pos + 1'b1;
                res.action     = ACT_SEND;
              end else if (state.restart_pending) begin
                // read address moves to buf[0], read count saturates
                wr.we   = 1'b1;
                wr.addr = '0;
                wr.data = rd_a;
                if (9'(rd_b) > 9'(BUFFER_DEPTH)) begin
                  state_next.len = CNT_W'(BUFFER_DEPTH);
                end else begin
                  state_next.len = CNT_W'(rd_b);
                end
                state_next.restart_pending = 1'b0;
                res.action                 = ACT_RSTART;
              end else begin
                state_next.busy = 1'b0;
                res.action      = ACT_STOP;
              end
            end
            ST_ADDR_R_ACK: begin
              res.action = ((XA_W'(state.pos) + 1'b1) < XA_W'(state.len)) ?
                           ACT_ACK : ACT_NACK;
            end
            ST_DATA_R_ACK: begin
              wr.we   = pos_in_buf;
              wr.addr = state.pos[ADDR_W-1:0];
              wr.data = item.data_byte;
              pos_inc = pos_in_buf ? state.pos + 1'b1 : state.pos;
              state_next.pos = pos_inc;
              res.action = ((XA_W'(pos_inc) + 1'b1) < XA_W'(state.len)) ?
                           ACT_ACK : ACT_NACK;
            end
            ST_DATA_R_NACK: begin
              wr.we           = pos_in_buf;
              wr.addr         = state.pos[ADDR_W-1:0];
              wr.data         = item.data_byte;
              state_next.busy = 1'b0;
              res.action      = ACT_STOP;
            end
            ST_IGNORED: begin
              res.action = ACT_NONE;
            end
            ST_ADDR_R_NACK, ST_ADDR_W_NACK, ST_DATA_W_NACK: begin
              state_next.err  = 1'b1;
              state_next.busy = 1'b0;
              res.action      = ACT_STOP;
            end
            default: begin
              state_next.busy = 1'b0;
              res.action      = ACT_RESET;
            end
          endcase
        end
      end
    endcase

    res.busy_res = state_next.busy;
    res.error    = state_next.err;
  end

endmodule

// ===== hdl/i2c_master_transfer_sequencer_core.sv =====
// I2C master byte-level sequencer. One word is taken per clock cycle when the
// result side keeps up; each word gives exactly one result word, which
// passes through the input register and then the result register. Buffer
// reads are launched from the accepted word and the state left by the word
// ahead of it, into two copies of a BUFFER_DEPTH x 8 RAM with registered read
// (one copy serves buf[index]/buf[position]/buf[length], the other
// buf[length+1]); a write by the word ahead is forwarded. s_tuser carries the
// command (write, read, launch, bus status event). Buffer contents are not
// cleared by reset.
module i2c_master_transfer_sequencer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // index[4:0], data_byte[12:5], length[17:13], restart_read[18], status[22:19]
  input  logic [i2cms_pkg::IN_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]                 s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // action[2:0], tx_byte[10:3], read_byte[18:11], busy_res[19], error[20],
  // refused[21]
  output logic [i2cms_pkg::OUT_W-1:0] m_tdata
);
  import i2cms_pkg::*;

  // Stage and handshake control
  logic      s1_valid;
  logic      accept;
  logic      fire;
  item_t     item;
  item_t     item_in;

  // State
  state_t    state;
  state_t    step_state;
  state_t    state_eff;
  result_t   res;
  wr_t       wr;
  logic      wr_en;

  // Buffer read path
  logic [XA_W-1:0]   a_x;
  logic [XA_W-1:0]   b_x;
  logic [CNT_W-1:0]  a_pos;
  logic [7:0]        q_a;
  logic [7:0]        q_b;
  logic [7:0]        rd_a;
  logic [7:0]        rd_b;
  logic              a_oob;
  logic              b_oob;
  logic              fwd_a;
  logic              fwd_b;
  logic [7:0]        fwd_data;

  // Output register
  logic                 out_valid;
  logic [OUT_W-1:0]     out_data;
  logic [OUT_W-1:0]     out_data_next;

  assign fire     = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || fire;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Unpack incoming word
  always_comb begin
    item_in.cmd          = cmd_t'(s_tuser);
    item_in.index        = s_tdata[I_IDX_LO +: INDEX_W];
    item_in.data_byte    = s_tdata[I_DATA_LO +: 8];
    item_in.length       = s_tdata[I_LEN_LO +: LENGTH_W];
    item_in.restart_read = s_tdata[I_RS_BIT];
    item_in.status       = s_tdata[I_STAT_LO +: 4];
  end

  // State as seen by the incoming word
  assign state_eff = fire ? step_state : state;
  assign wr_en     = fire && wr.we;

  // Read addresses for the incoming word
  always_comb begin
    a_pos = (item_in.status <= ST_REP_START) ? '0 : state_eff.pos;
    if (item_in.cmd == CMD_READ) begin
      a_x = XA_W'(item_in.index);
    end else if (a_pos < state_eff.len) begin
      a_x = XA_W'(a_pos);
    end else begin
      a_x = XA_W'(state_eff.len);
    end
    b_x = XA_W'(state_eff.len) + 1'b1;
  end

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (accept),
    .raddr (a_x[ADDR_W-1:0]),
    .rdata (q_a)
  );

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (accept),
    .raddr (b_x[ADDR_W-1:0]),
    .rdata (q_b)
  );

  // Input register with range flags and write forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= item_in;
      a_oob    <= a_x >= XA_W'(BUFFER_DEPTH);
      b_oob    <= b_x >= XA_W'(BUFFER_DEPTH);
      fwd_a    <= wr_en && (wr.addr == a_x[ADDR_W-1:0]);
      fwd_b    <= wr_en && (wr.addr == b_x[ADDR_W-1:0]);
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  assign rd_a = a_oob ? 8'd0 : (fwd_a ? fwd_data : q_a);
  assign rd_b = b_oob ? 8'd0 : (fwd_b ? fwd_data : q_b);

  i2cms_step u_step (
    .item       (item),
    .state      (state),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .state_next (step_state),
    .res        (res),
    .wr         (wr)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= step_state;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Pack result word, pad bits zero
  always_comb begin
    out_data_next                  = '0;
    out_data_next[O_ACT_LO +: 3]   = res.action;
    out_data_next[O_TX_LO +: 8]    = res.tx_byte;
    out_data_next[O_RD_LO +: 8]    = res.read_byte;
    out_data_next[O_BUSY_BIT]      = res.busy_res;
    out_data_next[O_ERR_BIT]       = res.error;
    out_data_next[O_REF_BIT]       = res.refused;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== hdl/i2cms_checker.sv =====
`include "i2c_master_transfer_sequencer_core_macros.svh"

// Port-level checks on the sequencer core.
module i2cms_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [i2cms_pkg::OUT_W-1:0] m_tdata
);
  import i2cms_pkg::*;

  logic [2:0] act;
  logic       busy;
  logic       err;
  logic       refused;
  logic       tx_zero;
  logic       stall;
  logic       tx_ok;
  logic       ref_ok;
  logic       ends;
  logic       busy_ok;
  logic       pad_zero;

  assign act      = m_tdata[O_ACT_LO +: 3];
  assign busy     = m_tdata[O_BUSY_BIT];
  assign err      = m_tdata[O_ERR_BIT];
  assign refused  = m_tdata[O_REF_BIT];
  assign tx_zero  = m_tdata[O_TX_LO +: 8] == 8'd0;
  assign stall    = m_tvalid && !m_tready;
  assign tx_ok    = (act == ACT_SEND) || tx_zero;
  assign ref_ok   = !refused || ((act == ACT_NONE) && busy);
  assign ends     = (act == ACT_STOP) || (act == ACT_RESET);
  assign busy_ok  = (act == ACT_START) ? (busy && !err) : (!ends || !busy);
  assign pad_zero = m_tdata[OUT_W-1:O_REF_BIT+1] == '0;

  // stalled result word holds
  `I2CMS_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(m_tdata), "stalled result changed")

  // tx byte only carries data with a send action
  `I2CMS_ASSERT_ALWAYS(a_tx_only_send, !m_tvalid || tx_ok, "tx byte set without send action")

  // a refused word does nothing and is only seen while busy
  `I2CMS_ASSERT_ALWAYS(a_refused, !m_tvalid || ref_ok, "refused word with action or idle")

  // start leaves busy with error clear; stop and reset leave idle
  `I2CMS_ASSERT_ALWAYS(a_busy_act, !m_tvalid || busy_ok, "busy flag inconsistent with action")

  // unused top pad bits stay zero
  `I2CMS_ASSERT_ALWAYS(a_pad_zero, !m_tvalid || pad_zero, "pad bits set in result word")

endmodule

bind i2c_master_transfer_sequencer_core i2cms_checker u_checker (.*);

// ===== tb/tb_i2c_master_transfer_sequencer_core.sv =====
module tb_i2c_master_transfer_sequencer_core;
  import i2cms_pkg::*;

  localparam int         CYCLE_LIMIT     = 600000;
  localparam int         ITEM_TARGET     = 1450;
  localparam int         LONG_HOLD       = 300;
  localparam logic [3:0] ST_BUS_ERROR    = 4'd11;
  localparam logic [3:0] ST_UNKNOWN      = 4'd15;
  localparam logic [7:0] OVERSIZED_COUNT = 8'hF8;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;   // index, data_byte, length, restart_read, status
  logic [1:0]          s_tuser;   // cmd
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;   // action, tx_byte, read_byte, busy_res, error, refused

  i2c_master_transfer_sequencer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Sequencer state as the testbench sees it
  logic [7:0] seq_buf [BUFFER_DEPTH];
  int         seq_pos = 0;
  int         seq_len = 0;
  bit         seq_restart = 1'b0;
  bit         seq_busy = 1'b0;
  bit         seq_err = 1'b0;
  action_t    seq_last_action = ACT_NONE;

  result_t    awaited_results [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         rx_wait = 0;
  int         hold_left = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("i2c_master_transfer_sequencer_core verification failed");
    $finish;
  end

  function automatic logic [7:0] buf_rd(int i);
    return (i < BUFFER_DEPTH) ? seq_buf[i] : 8'h00;
  endfunction

  function automatic void buf_wr(int i, logic [7:0] v);
    if (i < BUFFER_DEPTH) seq_buf[i] = v;
  endfunction

  // Next bus action and flags for one accepted word
  function automatic result_t step_sequencer(item_t it);
    result_t r;
    int      cnt;
    r = '0;
    r.action = ACT_NONE;
    case (it.cmd)
      CMD_WRITE: begin
        if (seq_busy) r.refused = 1'b1;
        else buf_wr(int'(it.index), it.data_byte);
      end
      CMD_READ: r.read_byte = buf_rd(int'(it.index));
      CMD_LAUNCH: begin
        if (seq_busy) begin
          r.refused = 1'b1;
        end else begin
          seq_len = int'(it.length);
          seq_restart = it.restart_read;
          seq_pos = 0;
          seq_busy = 1'b1;
          seq_err = 1'b0;
          r.action = ACT_START;
        end
      end
      default: begin
        if (seq_busy) begin
          case (it.status)
            ST_START, ST_REP_START, ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
              if (it.status == ST_START || it.status == ST_REP_START) seq_pos = 0;
              if (seq_pos < seq_len) begin
                r.tx_byte = buf_rd(seq_pos);
                seq_pos++;
                r.action = ACT_SEND;
              end else if (seq_restart) begin
                // read address and count sit just past the write bytes
                cnt = int'(buf_rd(seq_len + 1));
                buf_wr(0, buf_rd(seq_len));
                seq_len = (cnt > BUFFER_DEPTH) ? BUFFER_DEPTH : cnt;
                seq_restart = 1'b0;
                r.action = ACT_RSTART;
              end else begin
                seq_busy = 1'b0;
                r.action = ACT_STOP;
              end
            end
            ST_ADDR_R_ACK, ST_DATA_R_ACK: begin
              if (it.status == ST_DATA_R_ACK) begin
                buf_wr(seq_pos, it.data_byte);
                if (seq_pos < BUFFER_DEPTH) seq_pos++;
              end
              r.action = (seq_pos + 1 < seq_len) ? ACT_ACK : ACT_NACK;
            end
            ST_DATA_R_NACK: begin
              buf_wr(seq_pos, it.data_byte);
              seq_busy = 1'b0;
              r.action = ACT_STOP;
            end
            ST_IGNORED: r.action = ACT_NONE;
            ST_ADDR_R_NACK, ST_ADDR_W_NACK, ST_DATA_W_NACK: begin
              seq_err = 1'b1;
              seq_busy = 1'b0;
              r.action = ACT_STOP;
            end
            default: begin
              seq_busy = 1'b0;
              r.action = ACT_RESET;
            end
          endcase
        end
      end
    endcase
    r.busy_res = seq_busy;
    r.error = seq_err;
    seq_last_action = r.action;
    return r;
  endfunction

  // Offer one word after a random gap; predict once it is taken
  task automatic send_item(item_t it);
    int              gap;
    logic [IN_W-1:0] word;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    word = '0;
    word[I_IDX_LO +: INDEX_W] = it.index;
    word[I_DATA_LO +: 8] = it.data_byte;
    word[I_LEN_LO +: LENGTH_W] = it.length;
    word[I_RS_BIT] = it.restart_read;
    word[I_STAT_LO +: 4] = it.status;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_results.push_back(step_sequencer(it));
    items_sent++;
  endtask

  function automatic item_t any_item(cmd_t c);
    item_t it;
    it.cmd = c;
    it.index = INDEX_W'($urandom_range(0, 31));
    it.data_byte = 8'($urandom_range(0, 255));
    it.length = LENGTH_W'($urandom_range(0, 31));
    it.restart_read = 1'($urandom_range(0, 1));
    it.status = 4'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic send_write(int idx, int val);
    item_t it;
    it = any_item(CMD_WRITE);
    it.index = INDEX_W'(idx);
    it.data_byte = 8'(val);
    send_item(it);
  endtask

  task automatic send_read(int idx);
    item_t it;
    it = any_item(CMD_READ);
    it.index = INDEX_W'(idx);
    send_item(it);
  endtask

  task automatic send_launch(int len, bit rs);
    item_t it;
    it = any_item(CMD_LAUNCH);
    it.length = LENGTH_W'(len);
    it.restart_read = rs;
    send_item(it);
  endtask

  task automatic send_event(logic [3:0] st);
    item_t it;
    it = any_item(CMD_EVENT);
    it.status = st;
    send_item(it);
  endtask

  // Stop offering words and wait for every result to come back
  task automatic wait_drained();
    @(negedge clk) s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: per-word random stalls, plus a long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.action = action_t'(m_tdata[O_ACT_LO +: 3]);
      got.tx_byte = m_tdata[O_TX_LO +: 8];
      got.read_byte = m_tdata[O_RD_LO +: 8];
      got.busy_res = m_tdata[O_BUSY_BIT];
      got.error = m_tdata[O_ERR_BIT];
      got.refused = m_tdata[O_REF_BIT];
      if (awaited_results.size() == 0) begin
        $error("result word with no prediction pending");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("action", int'(want.action), int'(got.action));
        check_field("tx_byte", int'(want.tx_byte), int'(got.tx_byte));
        check_field("read_byte", int'(want.read_byte), int'(got.read_byte));
        check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
        check_field("error", int'(want.error), int'(got.error));
        check_field("refused", int'(want.refused), int'(got.refused));
      end
      rx_wait = idle_on ? $urandom_range(0, 16) : 0;
    end
  end

  // Whole buffer written first so no later read touches a stale entry
  task automatic test_buffer_fill();
    for (int i = 0; i < BUFFER_DEPTH; i++)
      send_write(i, (i == 0) ? 8'h00 : (i == BUFFER_DEPTH - 1) ? 8'hFF : $urandom_range(0, 255));
    send_read(0);
    send_read(BUFFER_DEPTH - 1);
    // bus event with nothing in flight
    send_event(ST_START);
  endtask

  task automatic test_write_transfer();
    send_launch(3, 1'b0);
    send_event(ST_START);
    send_write(7, 8'h5A);      // refused while busy
    send_launch(31, 1'b1);     // refused while busy
    send_read(5);              // allowed while busy
    send_event(ST_IGNORED);
    send_event(ST_ADDR_W_ACK);
    send_event(ST_DATA_W_ACK);
    send_event(ST_DATA_W_ACK);
  endtask

  task automatic test_restart_read();
    send_write(2, 8'hA1);
    send_write(3, OVERSIZED_COUNT);   // count saturates to the buffer depth
    send_launch(2, 1'b1);
    send_event(ST_START);
    send_event(ST_ADDR_W_ACK);
    send_event(ST_DATA_W_ACK);
    send_event(ST_REP_START);
    send_event(ST_ADDR_R_ACK);
    send_event(ST_DATA_R_ACK);
    send_event(ST_DATA_R_ACK);
    send_event(ST_DATA_R_NACK);
    // zero-length launch goes straight to the repeated start
    send_launch(0, 1'b1);
    send_event(ST_START);
    send_event(ST_BUS_ERROR);
  endtask

  task automatic test_error_endings();
    logic [3:0] nacks [3];
    nacks = '{ST_ADDR_R_NACK, ST_ADDR_W_NACK, ST_DATA_W_NACK};
    foreach (nacks[k]) begin
      send_launch(1, 1'b0);
      send_event(ST_START);
      send_event(nacks[k]);
    end
    send_read(1);              // error stays up until the next launch
    send_launch(1, 1'b0);
    send_event(ST_UNKNOWN);
    send_launch(1, 1'b0);
    send_event(ST_BUS_ERROR);
  endtask

  // One launch answered the way a bus would, with some noise mixed in
  task automatic run_transfer();
    int      ln;
    int      steps;
    bit      rs;
    bit      reading;
    action_t reply_to;
    item_t   it;
    ln = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 6);
    rs = 1'($urandom_range(0, 1));
    repeat ($urandom_range(0, 2)) send_write($urandom_range(0, 31), $urandom_range(0, 255));
    if (rs) begin
      send_write(ln, $urandom_range(0, 255));
      if (ln < 31)
        send_write(ln + 1, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 6));
    end
    send_launch(ln, rs);
    reading = 1'b0;
    steps = 0;
    reply_to = seq_last_action;
    while (seq_busy && steps < 90) begin
      steps++;
      if ($urandom_range(0, 24) == 0) begin
        it = any_item(cmd_t'($urandom_range(0, 3)));
        send_item(it);
      end else begin
        case (reply_to)
          ACT_START: send_event(ST_START);
          ACT_RSTART: begin
            reading = 1'b1;
            send_event(ST_REP_START);
          end
          ACT_SEND: send_event(reading ? ST_ADDR_R_ACK :
                               ($urandom_range(0, 1) ? ST_ADDR_W_ACK : ST_DATA_W_ACK));
          ACT_ACK: send_event(ST_DATA_R_ACK);
          ACT_NACK: send_event(ST_DATA_R_NACK);
          default: send_event(4'($urandom_range(0, 15)));
        endcase
      end
      if (seq_last_action != ACT_NONE) reply_to = seq_last_action;
    end
    if (seq_busy) send_event(ST_BUS_ERROR);
  endtask

  // Receiver holds off while the sender keeps pushing words
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left = LONG_HOLD;
    repeat (3) run_transfer();
    repeat (12) send_read($urandom_range(0, 31));
    idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_transfers();
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        send_event(4'($urandom_range(0, 15)));
        send_read($urandom_range(0, 31));
      end
      run_transfer();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_buffer_fill();
    test_write_transfer();
    test_restart_read();
    test_error_endings();
    test_backpressure();
    test_random_transfers();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("i2c_master_transfer_sequencer_core verification clean");
    end else begin
      $display("i2c_master_transfer_sequencer_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/i2cms_pkg.sv
hdl/i2cms_ram.sv
hdl/i2cms_step.sv
hdl/i2c_master_transfer_sequencer_core.sv
hdl/i2cms_checker.sv
tb/tb_i2c_master_transfer_sequencer_core.sv
